@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Real checks in simulation, empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or sequence property on every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: property failed");

// Check a plain expression on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("%m: invariant failed");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)

`endif

`endif

@@ hdl/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg
// Types, constants and helpers shared by the midpoint line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

    // Canvas and coordinate sizes
    localparam int CANVAS_SIZE = 512;
    localparam int COORD_W     = 9;
    localparam int DELTA_W     = 9;
    localparam int DEC_W       = 13;

    // Queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // Stream payload widths
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [DELTA_W-1:0] t_delta;
    typedef logic [DEC_W-1:0]   t_dec;

    // Request kinds
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // Octant modes: bit 0 steep, bit 1 left
    typedef enum logic [1:0] {
        OCT_SHALLOW_RIGHT = 2'd0,
        OCT_STEEP_RIGHT   = 2'd1,
        OCT_SHALLOW_LEFT  = 2'd2,
        OCT_STEEP_LEFT    = 2'd3
    } t_octant;

    // Classified request handed from front to back
    typedef struct packed {
        t_op     op;
        t_coord  x0;
        t_coord  y0;
        t_coord  x1;
        t_coord  y1;
        t_octant mode;
        t_delta  dmajor;
        t_delta  dminor;
        t_dec    decision;
    } t_cmd;

    // Queue status
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

    // Reduce a coordinate onto the canvas; smaller canvases must be powers of two
    function automatic t_coord take_coord(t_coord v);
        if (CANVAS_SIZE >= (1 << COORD_W)) begin
            return v;
        end else begin
            return v & t_coord'(CANVAS_SIZE - 1);
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/mlr_front.sv @@
// ----------------------------------------------------------------------------
// mlr_front
// Accepts requests, orders the endpoints and picks octant, deltas and the
// initial decision value for start requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlr_front
    import mlr_pkg::*;
(
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // start_x, start_y, end_x, end_y
    input  wire logic                 i_s_tuser,   // op
    input  wire t_fifo_stat           i_fifo_stat,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    t_coord  sx, sy, ex, ey;
    t_coord  x0, y0, x1, y1;
    logic    swap;
    logic    left;
    logic    steep;
    t_delta  adx, dy;
    t_delta  dmajor, dminor;

    // Unpack and reduce the endpoints
    assign sx = take_coord(i_s_tdata[COORD_W-1:0]);
    assign sy = take_coord(i_s_tdata[2*COORD_W-1:COORD_W]);
    assign ex = take_coord(i_s_tdata[3*COORD_W-1:2*COORD_W]);
    assign ey = take_coord(i_s_tdata[4*COORD_W-1:3*COORD_W]);

    // Order endpoints so the line runs downward, or rightward when flat
    always_comb begin
        swap = (ey < sy) || ((ey == sy) && (ex < sx));
        x0   = swap ? ex : sx;
        y0   = swap ? ey : sy;
        x1   = swap ? sx : ex;
        y1   = swap ? sy : ey;
    end

    // Classify the octant and derive deltas
    always_comb begin
        left   = (x1 < x0);
        adx    = left ? t_delta'(x0 - x1) : t_delta'(x1 - x0);
        dy     = t_delta'(y1 - y0);
        steep  = (adx < dy);
        dmajor = steep ? dy  : adx;
        dminor = steep ? adx : dy;
    end

    // Build the queue entry
    always_comb begin
        o_cmd.op       = t_op'(i_s_tuser);
        o_cmd.x0       = x0;
        o_cmd.y0       = y0;
        o_cmd.x1       = x1;
        o_cmd.y1       = y1;
        o_cmd.mode     = t_octant'({left, steep});
        o_cmd.dmajor   = dmajor;
        o_cmd.dminor   = dminor;
        o_cmd.decision = {3'b000, dminor, 1'b0} - {4'b0000, dmajor};
    end

    // Take a request whenever the queue has room
    assign o_s_tready = !i_fifo_stat.full;
    assign o_push     = i_s_tvalid && !i_fifo_stat.full;

endmodule

`default_nettype wire

@@ hdl/mlr_fifo.sv @@
// ----------------------------------------------------------------------------
// mlr_fifo
// Short show-ahead queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlr_fifo
    import mlr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_fifo_stat o_stat
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Present the head entry and status
    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

@@ hdl/mlr_back.sv @@
// ----------------------------------------------------------------------------
// mlr_back
// Holds the line state, runs one midpoint step per request and drives the
// registered pixel output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlr_back
    import mlr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_fifo_stat            i_fifo_stat,
    input  wire t_cmd                  i_cmd,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]       o_m_tdata,  // pixel_x, pixel_y
    output logic                       o_m_tlast   // last_pixel
);

    // Line state
    t_coord  r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    t_delta  r_dmajor, r_dminor;
    t_dec    r_decision;
    t_octant r_mode;
    logic    r_active;

    // Output register
    logic    r_out_valid;
    t_coord  r_px, r_py;
    logic    r_last;

    // Working values
    logic    is_start;
    logic    emit;
    t_coord  e_x, e_y, e_sx, e_sy;
    t_delta  e_dmajor, e_dminor;
    t_dec    e_dec;
    t_octant e_mode;
    logic    steep, left, last, dec_pos;
    t_coord  n_x, n_y, x_major;
    t_dec    n_dec;

    // Pop when the output slot is free or being drained
    assign o_pop    = !i_fifo_stat.empty && (!r_out_valid || i_m_tready);
    assign is_start = (i_cmd.op == OP_START);
    assign emit     = o_pop && (is_start || r_active);

    // Select loaded setup for a start, held state for a step
    always_comb begin
        e_x      = is_start ? i_cmd.x0       : r_cur_x;
        e_y      = is_start ? i_cmd.y0       : r_cur_y;
        e_sx     = is_start ? i_cmd.x1       : r_stop_x;
        e_sy     = is_start ? i_cmd.y1       : r_stop_y;
        e_dmajor = is_start ? i_cmd.dmajor   : r_dmajor;
        e_dminor = is_start ? i_cmd.dminor   : r_dminor;
        e_dec    = is_start ? i_cmd.decision : r_decision;
        e_mode   = is_start ? i_cmd.mode     : r_mode;
    end

    // Midpoint step: major axis always advances, minor on positive decision
    always_comb begin
        steep   = (e_mode == OCT_STEEP_RIGHT) || (e_mode == OCT_STEEP_LEFT);
        left    = (e_mode == OCT_SHALLOW_LEFT) || (e_mode == OCT_STEEP_LEFT);
        last    = steep ? (e_y == e_sy) : (e_x == e_sx);
        dec_pos = !e_dec[DEC_W-1] && (e_dec != '0);
        x_major = left ? e_x - 1'b1 : e_x + 1'b1;
        n_x     = steep ? (dec_pos ? x_major : e_x) : x_major;
        n_y     = (steep || dec_pos) ? e_y + 1'b1 : e_y;
        n_dec   = e_dec + {3'b000, e_dminor, 1'b0}
                - (dec_pos ? {3'b000, e_dmajor, 1'b0} : t_dec'(0));
    end

    // Hold line state, advance on each emitted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_stop_x   <= '0;
            r_stop_y   <= '0;
            r_dmajor   <= '0;
            r_dminor   <= '0;
            r_decision <= '0;
            r_mode     <= OCT_SHALLOW_RIGHT;
            r_active   <= 1'b0;
        end else if (emit) begin
            r_stop_x   <= e_sx;
            r_stop_y   <= e_sy;
            r_dmajor   <= e_dmajor;
            r_dminor   <= e_dminor;
            r_mode     <= e_mode;
            r_active   <= !last;
            if (!last) begin
                r_cur_x    <= n_x;
                r_cur_y    <= n_y;
                r_decision <= n_dec;
            end else begin
                r_cur_x    <= e_x;
                r_cur_y    <= e_y;
                r_decision <= e_dec;
            end
        end
    end

    // Load the output register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_px   <= e_x;
            r_py   <= e_y;
            r_last <= last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - 2*COORD_W)'(0), r_py, r_px};
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

@@ hdl/midpoint_line_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit
// Integer midpoint line rasterizer with a decoupled front end and back end.
// ----------------------------------------------------------------------------
// A start request (tuser = 0) carries two endpoints in tdata and yields the
// first pixel; each step request (tuser = 1) yields the next pixel, with
// tlast on the endpoint pixel. Steps with no line in progress yield nothing,
// and a start abandons any line in progress. The unit takes one request per
// clock and gives one pixel per clock while the master stream does not stall;
// a pixel leaves through the two-entry request queue and the output register.
// Each pixel costs one add of twice the minor delta and one conditional
// subtract of twice the major delta in the back end's decision update.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module midpoint_line_rasterizer_unit
    import mlr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // start_x, start_y, end_x, end_y
    input  wire logic                 i_s_tuser,   // op
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,   // pixel_x, pixel_y
    output logic                      o_m_tlast    // last_pixel
);

    t_fifo_stat fifo_stat;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    logic       push;
    logic       pop;
    logic       start_idle;

    // Accept and classify requests
    mlr_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Queue classified requests
    mlr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (fifo_stat)
    );

    // Step the line and drive pixels
    mlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (fifo_stat),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Start request taken while the unit is idle
    assign start_idle = i_s_tvalid && o_s_tready && (i_s_tuser == OP_START)
                        && fifo_stat.empty && !o_m_tvalid;

    // Queue never holds more than its depth
    `ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, fifo_stat.count <= FIFO_CW'(FIFO_DEPTH))

    // A start into an idle unit shows its first pixel once it has passed the queue and the output register
    `ASSERT_PROP(a_start_latency, i_clk, i_rst_n, start_idle |-> ##2 o_m_tvalid)

endmodule

`default_nettype wire

@@ sim/tb_midpoint_line_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer_unit
// Self-checking bench for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
// Drives start and step requests into the slave stream. Sends a directed set
// first: step with no line, single point, flat and vertical lines, an endpoint
// swap, a tie in the decision term, both left octants, canvas-corner lines and
// a start that cuts a line short. After that come random lines, mostly short,
// that are walked to the end, walked past the end or abandoned part way.
// A scoreboard class predicts every pixel from the accepted requests and
// checks each pixel taken from the master stream in order. The sender idles in
// random bursts and the receiver stalls in changing patterns.
`timescale 1ns / 1ps

module tb_midpoint_line_rasterizer_unit;
    import mlr_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 100;
    localparam int COORD_MAX    = CANVAS_SIZE - 1;

    // Expected pixel as it leaves the master stream
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    // Predict pixels from accepted requests and match them in order
    class pixel_scoreboard;
        t_pixel      pending_pixels[$];
        t_coord      pos_x;
        t_coord      pos_y;
        t_coord      end_x;
        t_coord      end_y;
        int          major_len;
        int          minor_len;
        int          err_term;
        t_octant     mode;
        bit          drawing;
        int unsigned starts_seen;
        int unsigned steps_seen;
        int unsigned idle_steps;
        int unsigned pixels_checked;
        bit [3:0]    octants_seen;

        function new();
            pos_x          = '0;
            pos_y          = '0;
            end_x          = '0;
            end_y          = '0;
            major_len      = 0;
            minor_len      = 0;
            err_term       = 0;
            mode           = OCT_SHALLOW_RIGHT;
            drawing        = 1'b0;
            starts_seen    = 0;
            steps_seen     = 0;
            idle_steps     = 0;
            pixels_checked = 0;
            octants_seen   = '0;
        endfunction

        // Queue the current pixel, then advance along the major axis
        function void plot_next();
            bit     steep;
            bit     left;
            bit     at_end;
            t_pixel px;
            steep  = mode[0];
            left   = mode[1];
            at_end = steep ? (pos_y == end_y) : (pos_x == end_x);
            px.x   = pos_x;
            px.y   = pos_y;
            px.last = at_end;
            pending_pixels.push_back(px);
            if (at_end) begin
                drawing = 1'b0;
                return;
            end
            // Step the minor axis only when the midpoint lies past the line
            if (err_term > 0) begin
                if (steep) begin
                    pos_x = left ? pos_x - 1'b1 : pos_x + 1'b1;
                end else begin
                    pos_y = pos_y + 1'b1;
                end
                err_term -= 2 * major_len;
            end
            err_term += 2 * minor_len;
            if (steep) begin
                pos_y = pos_y + 1'b1;
            end else begin
                pos_x = left ? pos_x - 1'b1 : pos_x + 1'b1;
            end
        endfunction

        function void note_request(t_op op, t_coord sx, t_coord sy, t_coord ex, t_coord ey);
            t_coord x0;
            t_coord y0;
            t_coord x1;
            t_coord y1;
            int     dx;
            int     dy;
            int     adx;
            if (op == OP_STEP) begin
                steps_seen++;
                if (drawing) begin
                    plot_next();
                end else begin
                    idle_steps++;
                end
                return;
            end
            starts_seen++;
            x0 = sx;
            y0 = sy;
            x1 = ex;
            y1 = ey;
            // Order the endpoints so the line never runs upward
            if (y1 < y0 || (y1 == y0 && x1 < x0)) begin
                x0 = ex;
                y0 = ey;
                x1 = sx;
                y1 = sy;
            end
            dx  = int'(x1) - int'(x0);
            dy  = int'(y1) - int'(y0);
            adx = (dx < 0) ? -dx : dx;
            if (dx < 0) begin
                mode = (adx >= dy) ? OCT_SHALLOW_LEFT : OCT_STEEP_LEFT;
            end else begin
                mode = (dx >= dy) ? OCT_SHALLOW_RIGHT : OCT_STEEP_RIGHT;
            end
            octants_seen[mode] = 1'b1;
            if (mode[0]) begin
                major_len = dy;
                minor_len = adx;
            end else begin
                major_len = adx;
                minor_len = dy;
            end
            err_term = 2 * minor_len - major_len;
            pos_x    = x0;
            pos_y    = y0;
            end_x    = x1;
            end_y    = y1;
            drawing  = 1'b1;
            plot_next();
        endfunction

        function bit check_pixel(t_coord x, t_coord y, logic last, output string why);
            t_pixel want;
            why = "";
            if (pending_pixels.size() == 0) begin
                why = $sformatf("pixel (%0d,%0d) last=%0b with none expected", x, y, last);
                return 1'b0;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (want.x !== x || want.y !== y || want.last !== last) begin
                why = $sformatf("pixel got (%0d,%0d) last=%0b, want (%0d,%0d) last=%0b",
                                x, y, last, want.x, want.y, want.last);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending_count();
            return pending_pixels.size();
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tuser  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b1;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;

    pixel_scoreboard pixel_sb;
    int unsigned     mismatches  = 0;
    int unsigned     cycle_count = 0;
    int              burst_left  = 0;
    int              useful_items;
    int              line_items;

    midpoint_line_rasterizer_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // start_x, start_y, end_x, end_y
        .i_s_tuser  (s_tuser),     // op
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),   // pixel_x, pixel_y
        .o_m_tlast  (o_m_tlast)    // last_pixel
    );

    // Free-running clock, 4 ns period
    always #2 clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string why);
        if (mismatches < MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, why);
        end
        mismatches++;
    endtask

    // Hand one request to the slave stream; sender idles between bursts
    task automatic push_request(input t_op op, input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            repeat ($urandom_range(12, 1)) @(negedge clk);
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 50)
                                                     : $urandom_range(24, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({ey, ex, sy, sx});
        do @(posedge clk); while (!o_s_tready);
        @(negedge clk);
    endtask

    // Start a line, then request a number of further pixels
    task automatic trace_line(input t_coord sx, input t_coord sy, input t_coord ex,
                              input t_coord ey, input int nsteps);
        push_request(OP_START, sx, sy, ex, ey);
        repeat (nsteps) begin
            push_request(OP_STEP, t_coord'($urandom), t_coord'($urandom),
                         t_coord'($urandom), t_coord'($urandom));
        end
    endtask

    function automatic t_coord clamp_coord(int v);
        if (v < 0) begin
            return '0;
        end else if (v > COORD_MAX) begin
            return t_coord'(COORD_MAX);
        end
        return t_coord'(v);
    endfunction

    // Random line: mostly short, walked to its end, past it, or cut short
    task automatic draw_random_line(output int useful);
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
        int     span;
        int     pick;
        int     npix;
        int     nsteps;
        int     adx;
        int     ady;
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
            span = $urandom_range(8, 0);
        end else if (pick < 97) begin
            span = $urandom_range(48, 0);
        end else begin
            span = $urandom_range(COORD_MAX, 0);
        end
        x0  = t_coord'($urandom_range(COORD_MAX, 0));
        y0  = t_coord'($urandom_range(COORD_MAX, 0));
        x1  = clamp_coord(int'(x0) + int'($urandom_range(2 * span, 0)) - span);
        y1  = clamp_coord(int'(y0) + int'($urandom_range(2 * span, 0)) - span);
        adx = (x1 > x0) ? int'(x1 - x0) : int'(x0 - x1);
        ady = (y1 > y0) ? int'(y1 - y0) : int'(y0 - y1);
        npix = ((adx > ady) ? adx : ady) + 1;
        pick = $urandom_range(99, 0);
        if (pick < 75) begin
            nsteps = npix - 1 + (($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0);
        end else begin
            nsteps = $urandom_range(npix - 1, 0);
        end
        trace_line(x0, y0, x1, y1, nsteps);
        useful = 1 + ((nsteps < npix - 1) ? nsteps : npix - 1);
    endtask

    // Receiver stalls in one of four patterns, picked anew when the current run ends
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(3, 0);
            stall_left = $urandom_range(200, 20);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= $urandom_range(1, 0);
            end
            2: begin
                m_tready <= ($urandom_range(4, 0) != 0);
            end
            default: begin
                m_tready <= ($urandom_range(15, 0) == 0);
            end
        endcase
    end

    // Note accepted requests and check pixels at the rising edge
    always @(posedge clk) begin
        string why;
        if (rst_n) begin
            if (s_tvalid && o_s_tready) begin
                pixel_sb.note_request(t_op'(s_tuser), s_tdata[8:0], s_tdata[17:9],
                                      s_tdata[26:18], s_tdata[35:27]);
            end
            if (o_m_tvalid && m_tready) begin
                if (!pixel_sb.check_pixel(o_m_tdata[8:0], o_m_tdata[17:9], o_m_tlast, why)) begin
                    report_mismatch(why);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped at cycle limit with %0d pixels outstanding",
                     pixel_sb.pending_count());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        pixel_sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: step with no line, then single point and step past it
        push_request(OP_STEP, t_coord'(COORD_MAX), t_coord'(COORD_MAX),
                     t_coord'(COORD_MAX), t_coord'(COORD_MAX));
        trace_line(t_coord'(5), t_coord'(5), t_coord'(5), t_coord'(5), 1);
        // Flat line, flat line given backward, vertical line
        trace_line(t_coord'(0), t_coord'(0), t_coord'(3), t_coord'(0), 3);
        trace_line(t_coord'(3), t_coord'(7), t_coord'(0), t_coord'(7), 3);
        trace_line(t_coord'(10), t_coord'(0), t_coord'(10), t_coord'(3), 3);
        // Decision term starts at zero
        trace_line(t_coord'(0), t_coord'(0), t_coord'(2), t_coord'(1), 2);
        // Shallow left and steep left, each cut short by the next start
        trace_line(t_coord'(20), t_coord'(8), t_coord'(14), t_coord'(10), 2);
        trace_line(t_coord'(30), t_coord'(0), t_coord'(28), t_coord'(5), 2);
        // Canvas corners, abandoned after a step
        trace_line(t_coord'(0), t_coord'(0), t_coord'(COORD_MAX), t_coord'(COORD_MAX), 1);
        trace_line(t_coord'(COORD_MAX), t_coord'(0), t_coord'(0), t_coord'(COORD_MAX), 1);

        // Random lines
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            draw_random_line(line_items);
            useful_items += line_items;
        end
        s_tvalid <= 1'b0;

        // Drain outstanding pixels, then watch for strays
        while (pixel_sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pixel_sb.pending_count() != 0) begin
            report_mismatch($sformatf("%0d pixels never arrived", pixel_sb.pending_count()));
        end

        $display("Covered %0d line starts and %0d pixel steps (%0d with no line), %0d pixels checked",
                 pixel_sb.starts_seen, pixel_sb.steps_seen, pixel_sb.idle_steps,
                 pixel_sb.pixels_checked);
        $display("Octant modes hit %4b, mismatches %0d", pixel_sb.octants_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mlr_pkg.sv
hdl/mlr_front.sv
hdl/mlr_fifo.sv
hdl/mlr_back.sv
hdl/midpoint_line_rasterizer_unit.sv
sim/tb_midpoint_line_rasterizer_unit.sv
